// ===== design/fbfl_pkg.sv =====
package fbfl_pkg;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [31:0] request_size;
		logic [31:0] free_address;
	} req_t;

	typedef struct packed {
		logic        success;
		logic [31:0] chunk_address;
	} rsp_t;

	typedef struct packed {
		logic init_wr;
		logic rd_head;
		logic res_grant;
		logic res_ok;
		logic res_fail;
		logic pop;
		logic push_fast;
		logic div_start;
		logic div_step;
		logic push_div;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic init_last;
		logic is_free;
		logic size_ok;
		logic head_ok;
		logic in_range;
		logic need_div;
		logic out_free;
	} sts_t;

endpackage

// ===== design/fbfl_ram.sv =====
module fbfl_ram #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/fbfl_ctrl.sv =====
module fbfl_ctrl
	import fbfl_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [5:0] {
		S_INIT = 6'b000001,
		S_IDLE = 6'b000010,
		S_READ = 6'b000100,
		S_DIV  = 6'b001000,
		S_PUSH = 6'b010000,
		S_HOLD = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			S_INIT: begin
				cmd.init_wr = 1'b1;
				if (sts.init_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					if (!sts.is_free) begin
						if (sts.size_ok && sts.head_ok) begin
							cmd.rd_head   = 1'b1;
							cmd.res_grant = 1'b1;
							state_d       = S_READ;
						end else begin
							cmd.res_fail = 1'b1;
							state_d      = S_HOLD;
						end
					end else if (!sts.in_range) begin
						cmd.res_fail = 1'b1;
						state_d      = S_HOLD;
					end else if (sts.need_div) begin
						cmd.res_ok    = 1'b1;
						cmd.div_start = 1'b1;
						state_d       = S_DIV;
					end else begin
						cmd.res_ok    = 1'b1;
						cmd.push_fast = 1'b1;
						state_d       = S_HOLD;
					end
				end
			end
			S_READ: begin
				cmd.pop = 1'b1;
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end else begin
					state_d = S_HOLD;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				state_d      = S_PUSH;
			end
			S_PUSH: begin
				cmd.push_div = 1'b1;
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end else begin
					state_d = S_HOLD;
				end
			end
			S_HOLD: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_INIT;
			end
		endcase
	end

endmodule

// ===== design/fbfl_dp.sv =====
module fbfl_dp
	import fbfl_pkg::*;
#(
	parameter int NUM_CHUNKS  = 1024,
	parameter int CHUNK_BYTES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  req_t        req,
	output rsp_t        rsp,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);

	localparam int IW = $clog2(NUM_CHUNKS);
	localparam int LW = $clog2(NUM_CHUNKS + 1);
	localparam int SH = $clog2(CHUNK_BYTES);
	localparam logic POW2 = ((1 << SH) == CHUNK_BYTES);
	localparam logic [LW-1:0] END_MARK = LW'(NUM_CHUNKS);
	localparam logic [31:0] CB32 = 32'(CHUNK_BYTES);
	localparam logic [32:0] SPAN = 33'(64'(NUM_CHUNKS) * 64'(CHUNK_BYTES));
	localparam logic [31:0] RECIP = 32'((64'(1 << SH) - 64'(CHUNK_BYTES)) * (64'd1 << 32)
		/ 64'(CHUNK_BYTES) + 64'd1);

	logic [31:0]   pool_base_q;
	logic [LW-1:0] head_q;
	logic [IW-1:0] init_q;
	logic          rsp_valid_q;
	rsp_t          res_q;
	rsp_t          rsp_q;
	logic [31:0]   off_q;
	logic [31:0]   mulhi_q;

	logic [31:0]   offset;
	logic [31:0]   head_ext;
	logic [31:0]   grant_addr;
	logic [IW-1:0] fast_idx;
	logic [IW-1:0] div_idx;
	logic [IW-1:0] push_idx;
	logic [LW-1:0] link_rd;
	logic [LW-1:0] link_clamped;
	logic [LW-1:0] init_link;
	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	logic [LW-1:0] ram_wdata;
	logic [63:0]   prod;
	logic [32:0]   quot_sum;

	assign offset       = req.free_address - pool_base_q;
	assign head_ext     = 32'(head_q[IW-1:0]);
	assign grant_addr   = pool_base_q + head_ext * CB32;
	assign fast_idx     = IW'(offset >> SH);
	assign prod         = 64'(off_q) * 64'(RECIP);
	assign quot_sum     = {1'b0, off_q} + {1'b0, mulhi_q};
	assign div_idx      = IW'(quot_sum >> SH);
	assign push_idx     = cmd.push_div ? div_idx : fast_idx;
	assign link_clamped = (link_rd > END_MARK) ? END_MARK : link_rd;
	assign init_link    = LW'(init_q) + LW'(1);

	assign ram_we    = cmd.init_wr | cmd.push_fast | cmd.push_div;
	assign ram_waddr = cmd.init_wr ? init_q : push_idx;
	assign ram_wdata = cmd.init_wr ? init_link : head_q;

	fbfl_ram #(
		.WIDTH(LW),
		.DEPTH(NUM_CHUNKS)
	) u_link_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.rd_head),
		.raddr(head_q[IW-1:0]),
		.rdata(link_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q <= '0;
			head_q      <= '0;
			init_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				pool_base_q <= cfg_wdata;
			end
			if (cmd.init_wr) begin
				init_q <= init_q + IW'(1);
			end
			if (cmd.pop) begin
				head_q <= link_clamped;
			end else if (cmd.push_fast || cmd.push_div) begin
				head_q <= LW'(push_idx);
			end
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_grant) begin
			res_q <= '{success: 1'b1, chunk_address: grant_addr};
		end else if (cmd.res_ok) begin
			res_q <= '{success: 1'b1, chunk_address: 32'd0};
		end else if (cmd.res_fail) begin
			res_q <= '{success: 1'b0, chunk_address: 32'd0};
		end
		if (cmd.out_load) begin
			rsp_q <= res_q;
		end
		if (cmd.div_start) begin
			off_q <= offset;
		end
		if (cmd.div_step) begin
			mulhi_q <= prod[63:32];
		end
	end

	assign sts.init_last = (init_q == IW'(NUM_CHUNKS - 1));
	assign sts.is_free   = (req.kind == KIND_FREE);
	assign sts.size_ok   = (req.request_size <= CB32);
	assign sts.head_ok   = (head_q < END_MARK);
	assign sts.in_range  = ({1'b0, offset} < SPAN);
	assign sts.need_div  = !POW2;
	assign sts.out_free  = !rsp_valid_q || rsp_ready;

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

endmodule

// ===== design/fixed_block_free_list.sv =====
// Fixed-size chunk allocator: NUM_CHUNKS chunks of CHUNK_BYTES bytes starting at pool_base,
// kept as a LIFO free list in a link RAM with registered read. After reset a clearing pass
// writes the initial links with req_ready low; cfg writes are taken at any time. One
// request is in flight at a time. An allocate reads the head chunk's link from the link
// RAM before its result is loaded; a failed allocate or a refused free reads no RAM; a free
// writes its link at once if CHUNK_BYTES is a power of two, else after the registered
// reciprocal multiply that turns the address offset into a chunk index. A result waiting
// on rsp_ready delays the completion of the next request.
module fixed_block_free_list
	import fbfl_pkg::*;
#(
	parameter int NUM_CHUNKS  = 1024,
	parameter int CHUNK_BYTES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  req_t        req,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output rsp_t        rsp,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);

	cmd_t cmd;
	sts_t sts;

	fbfl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	fbfl_dp #(
		.NUM_CHUNKS (NUM_CHUNKS),
		.CHUNK_BYTES(CHUNK_BYTES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.req      (req),
		.rsp      (rsp),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

endmodule

// ===== design/fbfl_checker.sv =====
module fbfl_checker
	import fbfl_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request taken while another is in flight");

	a_fail_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.success) |-> (rsp.chunk_address == 32'd0))
		else $error("refused result carries an address");

	a_rsp_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> !$past(req_ready))
		else $error("result appeared without request processing");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
		else $error("stalled result changed");

endmodule

bind fixed_block_free_list fbfl_checker u_fbfl_checker (.*);

// ===== tb/fixed_block_free_list_tb.sv =====
module fixed_block_free_list_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fbfl_pkg::*;

	localparam int          NCHUNK    = 1024;
	localparam logic [31:0] CHUNK_SZ  = 32'd16;
	localparam logic [31:0] POOL_SPAN = 32'd16384;
	localparam int          N_STEPS   = 24;

	typedef struct packed {
		logic        kind;
		logic [31:0] size;
		logic [31:0] addr;
		bit          typed;
		logic        ok;
		logic [31:0] where;
		bit          drain;
	} step_t;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_ready;
	req_t        req;
	logic        rsp_valid;
	logic        rsp_ready;
	rsp_t        rsp;
	logic        cfg_we;
	logic [31:0] cfg_wdata;

	logic [31:0] base_copy;
	logic [10:0] head_copy;
	logic [10:0] link_copy [NCHUNK];

	rsp_t outcome_q [$];
	int   held [$];
	int   bad_count = 0;
	int   next_gap = 0;
	bit   valid_held = 1'b0;
	bit   steady = 1'b0;
	int   rx_hold = 1;
	int   rx_pause;
	rsp_t rx_want;

	step_t script [N_STEPS] = '{
		'{KIND_ALLOC, 32'd0,          32'h0,          1'b1, 1'b1, 32'h0000_0000, 1'b0},
		'{KIND_ALLOC, 32'd16,         32'h0,          1'b1, 1'b1, 32'h0000_0010, 1'b0},
		'{KIND_ALLOC, 32'd17,         32'h0,          1'b1, 1'b0, 32'h0,         1'b0},
		'{KIND_ALLOC, 32'hFFFF_FFFF,  32'h0,          1'b1, 1'b0, 32'h0,         1'b0},
		'{KIND_FREE,  32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, 1'b0, 32'h0,         1'b0},
		'{KIND_FREE,  32'd0,          32'h0000_4000,  1'b1, 1'b0, 32'h0,         1'b0},
		'{KIND_FREE,  32'd0,          32'h0000_0010,  1'b1, 1'b1, 32'h0,         1'b0},
		'{KIND_ALLOC, 32'd1,          32'h0,          1'b1, 1'b1, 32'h0000_0010, 1'b0},
		'{KIND_FREE,  32'd0,          32'h0000_001F,  1'b1, 1'b1, 32'h0,         1'b0},
		'{KIND_ALLOC, 32'd8,          32'h0,          1'b1, 1'b1, 32'h0000_0010, 1'b0},
		'{KIND_FREE,  32'hFFFF_FFFF,  32'h0000_0000,  1'b1, 1'b1, 32'h0,         1'b0},
		'{KIND_ALLOC, 32'd0,          32'hFFFF_FFFF,  1'b1, 1'b1, 32'h0000_0000, 1'b0},
		'{KIND_ALLOC, 32'd0,          32'h0,          1'b0, 1'b0, 32'h0,         1'b1},
		'{KIND_ALLOC, 32'd0,          32'h0,          1'b1, 1'b0, 32'h0,         1'b0},
		'{KIND_ALLOC, 32'd17,         32'h0,          1'b1, 1'b0, 32'h0,         1'b0},
		'{KIND_FREE,  32'd0,          32'h0000_3FF5,  1'b1, 1'b1, 32'h0,         1'b0},
		'{KIND_ALLOC, 32'd16,         32'h0,          1'b1, 1'b1, 32'h0000_3FF0, 1'b0},
		'{KIND_ALLOC, 32'd0,          32'h0,          1'b1, 1'b0, 32'h0,         1'b0},
		'{KIND_FREE,  32'd0,          32'h0000_3FF0,  1'b1, 1'b1, 32'h0,         1'b0},
		'{KIND_FREE,  32'd0,          32'h0000_0020,  1'b1, 1'b1, 32'h0,         1'b0},
		'{KIND_FREE,  32'd0,          32'h0000_0020,  1'b1, 1'b1, 32'h0,         1'b0},
		'{KIND_ALLOC, 32'd4,          32'h0,          1'b1, 1'b1, 32'h0000_0020, 1'b0},
		'{KIND_ALLOC, 32'd4,          32'h0,          1'b0, 1'b0, 32'h0,         1'b0},
		'{KIND_ALLOC, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, 1'b0, 32'h0,         1'b0}
	};

	fixed_block_free_list #(
		.NUM_CHUNKS (NCHUNK),
		.CHUNK_BYTES(16)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic int pick_gap();
		return steady ? 0 : $urandom_range(0, 3);
	endfunction

	task automatic pool_apply(input req_t r, output rsp_t o, output int idx);
		logic [31:0] off;
		o = '0;
		idx = -1;
		if (r.kind == KIND_ALLOC) begin
			if (r.request_size <= CHUNK_SZ && head_copy < NCHUNK) begin
				idx = int'(head_copy);
				o.success = 1'b1;
				o.chunk_address = base_copy + 32'(head_copy) * CHUNK_SZ;
				head_copy = link_copy[head_copy];
				if (head_copy > NCHUNK) head_copy = 11'(NCHUNK);
			end
		end else begin
			off = r.free_address - base_copy;
			if (off < POOL_SPAN) begin
				idx = int'(off / CHUNK_SZ);
				link_copy[idx] = head_copy;
				head_copy = 11'(idx);
				o.success = 1'b1;
			end
		end
	endtask

	function automatic req_t pick_request();
		req_t r;
		int   u;
		int   h;
		r.request_size = $urandom;
		r.free_address = $urandom;
		u = $urandom_range(0, 99);
		h = $urandom_range(0, 99);
		if (u < 55) begin
			r.kind = KIND_ALLOC;
			if (h < 70) r.request_size = $urandom_range(0, 16);
			else if (h < 85) r.request_size = $urandom_range(17, 40);
		end else begin
			r.kind = KIND_FREE;
			if (h < 60 && held.size() != 0)
				r.free_address = base_copy
					+ 32'(held[$urandom_range(0, held.size() - 1)]) * CHUNK_SZ
					+ $urandom_range(0, 15);
			else if (h < 72)
				r.free_address = base_copy + $urandom_range(0, NCHUNK - 1) * CHUNK_SZ
					+ $urandom_range(0, 15);
			else if (h < 84)
				r.free_address = base_copy + POOL_SPAN - CHUNK_SZ + $urandom_range(0, 31);
			else if (h < 92)
				r.free_address = base_copy - $urandom_range(1, 16);
		end
		return r;
	endfunction

	task automatic send(input req_t r, input bit typed, input rsp_t want);
		rsp_t o;
		int   idx;
		repeat (next_gap) @(posedge clk);
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		pool_apply(r, o, idx);
		outcome_q.push_back(typed ? want : o);
		if (o.success && r.kind == KIND_ALLOC) begin
			held.push_back(idx);
		end else if (o.success) begin
			foreach (held[k]) begin
				if (held[k] == idx) begin
					held.delete(k);
					break;
				end
			end
		end
		next_gap = pick_gap();
		// hold valid when the next transfer follows at once
		valid_held = (next_gap == 0);
		if (!valid_held) req_valid <= 1'b0;
	endtask

	task automatic quiesce();
		if (valid_held) begin
			req_valid <= 1'b0;
			valid_held = 1'b0;
		end
		do @(posedge clk); while (outcome_q.size() != 0);
		repeat (4) @(posedge clk);
		next_gap = 0;
	endtask

	task automatic set_base(input logic [31:0] v);
		quiesce();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		base_copy = v;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (outcome_q.size() == 0) begin
					$error("result with nothing outstanding: success %0d chunk_address %h",
						rsp.success, rsp.chunk_address);
					bad_count++;
				end else begin
					rx_want = outcome_q.pop_front();
					if (rsp.success !== rx_want.success) begin
						$error("success: expected %0d, got %0d", rx_want.success, rsp.success);
						bad_count++;
					end
					if (rsp.chunk_address !== rx_want.chunk_address) begin
						$error("chunk_address: expected %h, got %h",
							rx_want.chunk_address, rsp.chunk_address);
						bad_count++;
					end
				end
				rx_pause = pick_gap();
				if (rx_pause != 0) begin
					rsp_ready <= 1'b0;
					rx_hold <= rx_pause;
				end
			end else if (!rsp_ready) begin
				if (rx_hold <= 1) rsp_ready <= 1'b1;
				rx_hold <= rx_hold - 1;
			end
		end
	end

	initial begin
		#2_000_000;
		$display("fixed_block_free_list_tb: done, errors");
		$finish;
	end

	initial begin
		req_t        r;
		rsp_t        want;
		logic [31:0] bases [6];
		clk = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		base_copy = '0;
		head_copy = '0;
		for (int i = 0; i < NCHUNK; i++) link_copy[i] = 11'(i + 1);
		bases = '{32'hFFFF_FFF0, 32'h0001_2340, $urandom, 32'hFFFF_FFFF, 32'h0, $urandom};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (script[i]) begin
			r.kind = script[i].kind;
			r.request_size = script[i].size;
			r.free_address = script[i].addr;
			want.success = script[i].ok;
			want.chunk_address = script[i].where;
			if (script[i].drain) begin
				while (head_copy < NCHUNK) begin
					r.request_size = $urandom_range(0, 16);
					send(r, 1'b0, want);
				end
			end else begin
				send(r, script[i].typed, want);
			end
		end

		for (int p = 0; p < 6; p++) begin
			set_base(bases[p]);
			steady = (p == 2);
			for (int n = 0; n < 96; n++) begin
				if (p == 1 && n == 48) quiesce();
				send(pick_request(), 1'b0, '0);
			end
		end
		steady = 1'b0;
		quiesce();

		if (bad_count == 0) begin
			$display("fixed_block_free_list_tb: done, clean");
		end else begin
			$display("fixed_block_free_list_tb: done, errors");
		end
		$finish;
	end

endmodule
